>>> hw/rtl/mipd_pkg.sv
// Shared types, constants and register codes of the incremental PID drive.
package mipd_pkg;

   localparam int DATA_W     = 16;
   localparam int MIDX_W     = 2;
   localparam int DIR_W      = 2;
   localparam int DUTY_W     = 15;
   localparam int MASK_W     = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int ESUM_W     = 11;
   localparam int ERR_W      = 17;
   localparam int MAG_W      = 33;

   localparam int MOTORS_DEF      = 4;
   localparam int ENCODER_MID_DEF = 32768;

   localparam logic [DATA_W-1:0] GAIN_P_RST    = 16'd150;
   localparam logic [DATA_W-1:0] GAIN_I_RST    = 16'd10;
   localparam logic [DATA_W-1:0] GAIN_D_RST    = 16'd5;
   localparam logic [DUTY_W-1:0] PWM_LIMIT_RST = 15'd1000;
   localparam logic [MASK_W-1:0] REV_MASK_RST  = 4'd10;

   // error sum is held within +/- SUM_LIMIT
   localparam int SUM_LIMIT = 1000;

   // |num| / 100 as (|num| * DIV_RECIP) >> QUOT_LSB, exact for |num| < 2^33
   localparam logic [33:0] DIV_RECIP = 34'd10995116278;
   localparam logic [16:0] RECIP_HI  = DIV_RECIP[33:17];
   localparam logic [16:0] RECIP_LO  = DIV_RECIP[16:0];
   localparam int          QUOT_LSB  = 40;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_PWM_LIMIT = 3'd3,
      CSR_REV_MASK  = 3'd4
   } csr_idx_type;

   typedef enum logic [DIR_W-1:0] {
      DIR_STOP = 2'd0,
      DIR_FWD  = 2'd1,
      DIR_REV  = 2'd2
   } dir_type;

   // per-word side data carried down the pipe
   typedef struct packed {
      logic [MIDX_W-1:0] motor;
      logic              bad;
      logic              zero;
      logic [DATA_W-1:0] delta;
   } tag_type;

   // load enables of the divider's two register stages
   typedef struct packed {
      logic ld_pp;
      logic ld_q;
   } div_ctl_type;

endpackage

>>> hw/rtl/mipd_req_if.sv
// Control tick channel: motor, raw encoder count and target speed.
interface mipd_req_if;
   import mipd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MIDX_W-1:0]        motor_index;
   logic [DATA_W-1:0]        encoder_count;
   logic signed [DATA_W-1:0] set_speed;

   modport source (output valid, motor_index, encoder_count, set_speed, input ready);
   modport sink   (input valid, motor_index, encoder_count, set_speed, output ready);
endinterface

>>> hw/rtl/mipd_rsp_if.sv
// Drive result channel: direction, duty and diagnostic values for one motor.
interface mipd_rsp_if;
   import mipd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [MIDX_W-1:0]        motor_out;
   logic [DIR_W-1:0]         direction;
   logic [DUTY_W-1:0]        duty;
   logic signed [DATA_W-1:0] drive_level;
   logic signed [DATA_W-1:0] measured_delta;

   modport source (output valid, motor_out, direction, duty, drive_level, measured_delta,
                   input ready);
   modport sink   (input valid, motor_out, direction, duty, drive_level, measured_delta,
                   output ready);
endinterface

>>> hw/rtl/mipd_div100.sv
// Two-stage divide-by-100 of a 33-bit magnitude, low 16 quotient bits out.
module mipd_div100 (
   input  logic                          clock,
   input  mipd_pkg::div_ctl_type         ctl,
   input  logic [mipd_pkg::MAG_W-1:0]    mag,
   output logic [mipd_pkg::DATA_W-1:0]   quot
);
   import mipd_pkg::*;

   logic [15:0]       mag_hi;
   logic [16:0]       mag_lo;
   logic [32:0]       pp_hh_in, pp_hh_ff;
   logic [32:0]       pp_hl_in, pp_hl_ff;
   logic [33:0]       pp_lh_in, pp_lh_ff;
   logic [33:0]       pp_ll_in, pp_ll_ff;
   logic [34:0]       mid;
   logic [66:0]       full;
   logic [DATA_W-1:0] quot_in, quot_ff;

   assign mag_hi = mag[32:17];
   assign mag_lo = mag[16:0];

   // four 16x17 and 17x17 partial products of the reciprocal multiply
   assign pp_hh_in = mag_hi * RECIP_HI;
   assign pp_hl_in = mag_hi * RECIP_LO;
   assign pp_lh_in = mag_lo * RECIP_HI;
   assign pp_ll_in = mag_lo * RECIP_LO;

   always_ff @(posedge clock) begin
      if (ctl.ld_pp) begin
         pp_hh_ff <= pp_hh_in;
         pp_hl_ff <= pp_hl_in;
         pp_lh_ff <= pp_lh_in;
         pp_ll_ff <= pp_ll_in;
      end
   end

   assign mid     = 35'(pp_hl_ff) + 35'(pp_lh_ff);
   assign full    = {pp_hh_ff, 34'd0} + {15'd0, mid, 17'd0} + {33'd0, pp_ll_ff};
   assign quot_in = full[QUOT_LSB +: DATA_W];

   always_ff @(posedge clock) begin
      if (ctl.ld_q) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

>>> hw/rtl/motor_incremental_pid_drive.sv
// Top level: incremental PID drive pipeline for up to four motors.
//
// Usage:
//   req_ch carries one control tick per word: motor index, raw encoder count
//   and target speed. rsp_ch returns one drive word per tick, in order: motor,
//   direction (stop / forward / reverse), duty clamped to pwm_limit, the signed
//   drive accumulator and the measured encoder delta.
//   csr_* writes one register per cycle with csr_we high; index 0..2 are the
//   P, I and D gains (x100), 3 the PWM limit, 4 the reverse mask. A gain write
//   clears every motor's error sum and last error. Write only while idle.
// Timing:
//   One word is accepted every cycle unless an rsp_ch stall has backed up
//   the pipe; the seven-stage pipe is set by the three gain multiplies and
//   the split reciprocal multiply of the /100 in stages five and six.
//   Error state is updated in stage one and the drive accumulator in the last
//   stage, so ticks for the same motor may follow each other back to back.
// Reset and stalls:
//   Reset loads the default gains and clears all per-motor state and the pipe.
//   When rsp_ch stalls the pipe fills its bubbles first and then holds
//   req_ch.ready low; no word is lost or repeated.
module motor_incremental_pid_drive #(
   parameter int MOTORS      = mipd_pkg::MOTORS_DEF,
   parameter int ENCODER_MID = mipd_pkg::ENCODER_MID_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   mipd_req_if.sink                          req_ch,
   mipd_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [mipd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mipd_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mipd_pkg::*;

   localparam int                STAGES    = 7;
   localparam logic [MIDX_W:0]   MOTORS_W  = (MIDX_W + 1)'(MOTORS);
   localparam logic [DATA_W-1:0] MID_W     = DATA_W'(ENCODER_MID);

   // configuration
   logic signed [DATA_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [DUTY_W-1:0]        pwm_limit_ff;
   logic [MASK_W-1:0]        rev_mask_ff;
   logic                     gain_wr;

   // pipe control
   logic [STAGES:1] vld_ff;
   logic [STAGES:1] rdy;

   // per-motor state
   logic [ESUM_W-1:0] esum_ff [MOTORS];
   logic [ERR_W-1:0]  lerr_ff [MOTORS];
   logic [DATA_W-1:0] accum_ff [MOTORS];

   // stage 1
   logic [MIDX_W-1:0]        s1_motor_ff;
   logic [DATA_W-1:0]        s1_count_ff;
   logic [DATA_W-1:0]        s1_target_ff;
   logic [ESUM_W-1:0]        esum_sel;
   logic [ERR_W-1:0]         lerr_sel;
   logic                     bad1, zero1, rev1, st_upd;
   logic [DATA_W-1:0]        delta_raw, delta1;
   logic [ERR_W-1:0]         err1;
   logic [ERR_W:0]           sum_raw;
   logic signed [ERR_W:0]    sum_s;
   logic [ESUM_W-1:0]        esum1;
   logic [ERR_W:0]           diff1;
   tag_type                  tag1;

   // stage 2..6
   tag_type                  tag_ff [STAGES-1:2];
   logic signed [ERR_W-1:0]  s2_err_ff;
   logic signed [ESUM_W-1:0] s2_esum_ff;
   logic signed [ERR_W:0]    s2_diff_ff;
   logic signed [32:0]       prod_p_in, prod_p_ff;
   logic signed [26:0]       prod_i_in, prod_i_ff;
   logic signed [33:0]       prod_d_in, prod_d_ff;
   logic signed [34:0]       num, num_neg;
   logic [MAG_W-1:0]         s4_mag_ff;
   logic [STAGES-1:4]        neg_ff;
   div_ctl_type              div_ctl;
   logic [DATA_W-1:0]        quot;

   // stage 6 -> output
   logic [DATA_W-1:0]        accum_sel, inc, accum_new;
   logic [DATA_W-1:0]        mag_neg;
   logic                     acc_upd;
   dir_type                  dir_in;
   logic [DUTY_W-1:0]        duty_in;

   // ---------------- configuration ----------------
   assign gain_wr = csr_we && (csr_index == CSR_GAIN_P || csr_index == CSR_GAIN_I ||
                               csr_index == CSR_GAIN_D);

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= GAIN_P_RST;
         gain_i_ff    <= GAIN_I_RST;
         gain_d_ff    <= GAIN_D_RST;
         pwm_limit_ff <= PWM_LIMIT_RST;
         rev_mask_ff  <= REV_MASK_RST;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_PWM_LIMIT: pwm_limit_ff <= csr_wdata[DUTY_W-1:0];
            CSR_REV_MASK:  rev_mask_ff  <= csr_wdata[MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- pipe control ----------------
   // a stage loads when it is empty or its word moves on
   always_comb begin
      rdy[STAGES] = !vld_ff[STAGES] || rsp_ch.ready;
      for (int k = STAGES - 1; k >= 1; k--) begin
         rdy[k] = !vld_ff[k] || rdy[k+1];
      end
   end

   assign req_ch.ready = rdy[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[1]) vld_ff[1] <= req_ch.valid;
         for (int k = 2; k <= STAGES; k++) begin
            if (rdy[k]) vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // ---------------- stage 1: delta, error, error sum ----------------
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         s1_motor_ff  <= req_ch.motor_index;
         s1_count_ff  <= req_ch.encoder_count;
         s1_target_ff <= req_ch.set_speed;
      end
   end

   always_comb begin
      esum_sel = '0;
      lerr_sel = '0;
      for (int i = 0; i < MOTORS; i++) begin
         if (s1_motor_ff == MIDX_W'(i)) begin
            esum_sel = esum_ff[i];
            lerr_sel = lerr_ff[i];
         end
      end
   end

   always_comb begin
      bad1      = ({1'b0, s1_motor_ff} >= MOTORS_W);
      zero1     = (s1_target_ff == '0);
      rev1      = rev_mask_ff[s1_motor_ff];
      delta_raw = s1_count_ff - MID_W;
      delta1    = rev1 ? DATA_W'(16'd0 - delta_raw) : delta_raw;
      err1      = {s1_target_ff[DATA_W-1], s1_target_ff} - {delta1[DATA_W-1], delta1};
      sum_raw   = {{(ERR_W + 1 - ESUM_W){esum_sel[ESUM_W-1]}}, esum_sel}
                + {err1[ERR_W-1], err1};
      sum_s     = $signed(sum_raw);
      if (sum_s > (ERR_W + 1)'(SUM_LIMIT)) begin
         esum1 = ESUM_W'(SUM_LIMIT);
      end else if (sum_s < -(ERR_W + 1)'(SUM_LIMIT)) begin
         esum1 = ESUM_W'(-SUM_LIMIT);
      end else begin
         esum1 = sum_raw[ESUM_W-1:0];
      end
      diff1      = {err1[ERR_W-1], err1} - {lerr_sel[ERR_W-1], lerr_sel};
      tag1.motor = s1_motor_ff;
      tag1.bad   = bad1;
      tag1.zero  = zero1;
      tag1.delta = delta1;
   end

   assign st_upd = rdy[2] && vld_ff[1] && !bad1;

   always_ff @(posedge clock) begin
      for (int i = 0; i < MOTORS; i++) begin
         if (reset || gain_wr) begin
            esum_ff[i] <= '0;
            lerr_ff[i] <= '0;
         end else if (st_upd && s1_motor_ff == MIDX_W'(i)) begin
            esum_ff[i] <= zero1 ? '0 : esum1;
            lerr_ff[i] <= zero1 ? '0 : err1;
         end
      end
   end

   // ---------------- stage 2: gain products ----------------
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         tag_ff[2]  <= tag1;
         s2_err_ff  <= err1;
         s2_esum_ff <= esum1;
         s2_diff_ff <= diff1;
      end
   end

   assign prod_p_in = gain_p_ff * s2_err_ff;
   assign prod_i_in = gain_i_ff * s2_esum_ff;
   assign prod_d_in = gain_d_ff * s2_diff_ff;

   // ---------------- stage 3: sum and magnitude ----------------
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         tag_ff[3] <= tag_ff[2];
         prod_p_ff <= prod_p_in;
         prod_i_ff <= prod_i_in;
         prod_d_ff <= prod_d_in;
      end
   end

   assign num     = 35'(prod_p_ff) + 35'(prod_i_ff) + 35'(prod_d_ff);
   assign num_neg = -num;

   // ---------------- stages 4..6: divide by 100 toward zero ----------------
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         tag_ff[4] <= tag_ff[3];
         neg_ff[4] <= num[34];
         s4_mag_ff <= num[34] ? num_neg[MAG_W-1:0] : num[MAG_W-1:0];
      end
      if (rdy[5]) begin
         tag_ff[5] <= tag_ff[4];
         neg_ff[5] <= neg_ff[4];
      end
      if (rdy[6]) begin
         tag_ff[6] <= tag_ff[5];
         neg_ff[6] <= neg_ff[5];
      end
   end

   assign div_ctl.ld_pp = rdy[5];
   assign div_ctl.ld_q  = rdy[6];

   mipd_div100 u_div (
      .clock (clock),
      .ctl   (div_ctl),
      .mag   (s4_mag_ff),
      .quot  (quot)
   );

   // ---------------- stage 6: accumulate, clamp, output ----------------
   always_comb begin
      accum_sel = '0;
      for (int i = 0; i < MOTORS; i++) begin
         if (tag_ff[6].motor == MIDX_W'(i)) begin
            accum_sel = accum_ff[i];
         end
      end
   end

   always_comb begin
      inc       = neg_ff[6] ? DATA_W'(16'd0 - quot) : quot;
      accum_new = tag_ff[6].zero ? '0 : DATA_W'(accum_sel + inc);
      mag_neg   = DATA_W'(16'd0 - accum_new);
      dir_in    = DIR_STOP;
      duty_in   = '0;
      if (tag_ff[6].bad || accum_new == '0) begin
         dir_in  = DIR_STOP;
         duty_in = '0;
      end else if (!accum_new[DATA_W-1]) begin
         dir_in  = DIR_FWD;
         duty_in = (accum_new[DUTY_W-1:0] > pwm_limit_ff) ? pwm_limit_ff
                                                          : accum_new[DUTY_W-1:0];
      end else begin
         // the most negative drive has magnitude 2^15, still clamped
         dir_in  = DIR_REV;
         duty_in = ({1'b0, pwm_limit_ff} < mag_neg) ? pwm_limit_ff : mag_neg[DUTY_W-1:0];
      end
   end

   assign acc_upd = rdy[STAGES] && vld_ff[STAGES-1] && !tag_ff[6].bad;

   always_ff @(posedge clock) begin
      for (int i = 0; i < MOTORS; i++) begin
         if (reset) begin
            accum_ff[i] <= '0;
         end else if (acc_upd && tag_ff[6].motor == MIDX_W'(i)) begin
            accum_ff[i] <= accum_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[STAGES]) begin
         rsp_ch.motor_out      <= tag_ff[6].motor;
         rsp_ch.direction      <= dir_in;
         rsp_ch.duty           <= duty_in;
         rsp_ch.drive_level    <= tag_ff[6].bad ? '0 : accum_new;
         rsp_ch.measured_delta <= tag_ff[6].bad ? '0 : tag_ff[6].delta;
      end
   end

   assign rsp_ch.valid = vld_ff[STAGES];

`ifndef SYNTHESIS
   a_stop_no_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.direction == DIR_STOP |-> rsp_ch.duty == '0)
      else $error("stopped motor with nonzero duty");

   a_duty_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> rsp_ch.duty <= pwm_limit_ff)
      else $error("duty above pwm limit");

   a_esum_range: assert property (@(posedge clock) disable iff (reset)
      $signed(esum_sel) <= ESUM_W'(SUM_LIMIT) && $signed(esum_sel) >= ESUM_W'(-SUM_LIMIT))
      else $error("error sum out of range");

   a_gain_clear: assert property (@(posedge clock) disable iff (reset)
      gain_wr |=> esum_sel == '0 && lerr_sel == '0)
      else $error("gain write did not clear loop state");

   a_bad_motor_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && {1'b0, rsp_ch.motor_out} >= MOTORS_W
      |-> rsp_ch.drive_level == '0 && rsp_ch.direction == DIR_STOP)
      else $error("result for unknown motor not zero");
`endif

endmodule

>>> test/mipd_drive_checker.sv
// Checker for the PID drive: predicts each drive word and compares it with the result channel.
`timescale 1ns / 100ps

module mipd_drive_checker (
   input  logic                            clock,
   input  logic                            reset,
   mipd_req_if                             req_ch,
   mipd_rsp_if                             rsp_ch,
   input  logic                            csr_we,
   input  logic [mipd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mipd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              mismatches,
   output int                              pending_words
);
   import mipd_pkg::*;

   localparam int GAIN_SCALE = 100;
   localparam int REPORT_MAX = 10;

   typedef struct {
      logic [MIDX_W-1:0]        motor;
      dir_type                  dir;
      logic [DUTY_W-1:0]        duty;
      logic signed [DATA_W-1:0] level;
      logic signed [DATA_W-1:0] delta;
   } drive_word_type;

   // shared gains and limits
   logic signed [DATA_W-1:0] gain_p, gain_i, gain_d;
   logic [DUTY_W-1:0]        pwm_limit;
   logic [MASK_W-1:0]        rev_mask;

   // per-motor loop state
   logic signed [DATA_W-1:0] drive_accum [MOTORS_DEF];
   logic signed [ERR_W-1:0]  last_err    [MOTORS_DEF];
   logic signed [ESUM_W-1:0] err_sum     [MOTORS_DEF];

   drive_word_type drive_q [$];
   drive_word_type want;

   function automatic void clear_loops();
      for (int m = 0; m < MOTORS_DEF; m++) begin
         last_err[m] = '0;
         err_sum[m]  = '0;
      end
   endfunction

   function automatic void load_defaults();
      gain_p    = GAIN_P_RST;
      gain_i    = GAIN_I_RST;
      gain_d    = GAIN_D_RST;
      pwm_limit = PWM_LIMIT_RST;
      rev_mask  = REV_MASK_RST;
      for (int m = 0; m < MOTORS_DEF; m++)
         drive_accum[m] = '0;
      clear_loops();
   endfunction

   function automatic void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_GAIN_P: begin
            gain_p = data;
            clear_loops();
         end
         CSR_GAIN_I: begin
            gain_i = data;
            clear_loops();
         end
         CSR_GAIN_D: begin
            gain_d = data;
            clear_loops();
         end
         CSR_PWM_LIMIT: pwm_limit = data[DUTY_W-1:0];
         CSR_REV_MASK:  rev_mask  = data[MASK_W-1:0];
         default: ;
      endcase
   endfunction

   // one control tick: update that motor's loop and form its drive word
   function automatic drive_word_type predict_drive(logic [MIDX_W-1:0] motor,
                                                    logic [DATA_W-1:0] count,
                                                    logic signed [DATA_W-1:0] target);
      drive_word_type w;
      logic signed [DATA_W-1:0] delta;
      int     err, esum, level, mag;
      longint num, step;

      w.motor = motor;
      w.dir   = DIR_STOP;
      w.duty  = '0;
      w.level = '0;
      w.delta = '0;
      if (int'(motor) >= MOTORS_DEF)
         return w;

      delta = count - DATA_W'(ENCODER_MID_DEF);
      if (rev_mask[motor])
         delta = -delta;   // -32768 wraps onto itself

      if (target == 0) begin
         drive_accum[motor] = '0;
         err_sum[motor]     = '0;
         last_err[motor]    = '0;
      end else begin
         err  = int'(target) - int'(delta);
         esum = int'(err_sum[motor]) + err;
         if (esum > SUM_LIMIT)
            esum = SUM_LIMIT;
         else if (esum < -SUM_LIMIT)
            esum = -SUM_LIMIT;
         err_sum[motor] = ESUM_W'(esum);
         num = longint'(gain_p) * err + longint'(gain_i) * esum
             + longint'(gain_d) * (err - int'(last_err[motor]));
         step = num / GAIN_SCALE;   // truncates toward zero
         drive_accum[motor] = drive_accum[motor] + DATA_W'(step);
         last_err[motor] = ERR_W'(err);
      end

      level   = int'(drive_accum[motor]);
      w.level = drive_accum[motor];
      w.delta = delta;
      if (level > 0) begin
         w.dir  = DIR_FWD;
         w.duty = (level > int'(pwm_limit)) ? pwm_limit : DUTY_W'(level);
      end else if (level < 0) begin
         mag    = -level;
         w.dir  = DIR_REV;
         w.duty = (mag > int'(pwm_limit)) ? pwm_limit : DUTY_W'(mag);
      end
      return w;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         load_defaults();
         drive_q.delete();
         mismatches = 0;
      end else begin
         if (csr_we)
            write_reg(csr_index, csr_wdata);
         if (req_ch.valid && req_ch.ready)
            drive_q.push_back(predict_drive(req_ch.motor_index, req_ch.encoder_count,
                                            req_ch.set_speed));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (drive_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("unexpected drive word: m%0d dir %0d duty %0d level %0d delta %0d",
                           rsp_ch.motor_out, rsp_ch.direction, rsp_ch.duty,
                           rsp_ch.drive_level, rsp_ch.measured_delta);
            end else begin
               want = drive_q.pop_front();
               if (rsp_ch.motor_out !== want.motor || rsp_ch.direction !== want.dir ||
                   rsp_ch.duty !== want.duty || rsp_ch.drive_level !== want.level ||
                   rsp_ch.measured_delta !== want.delta) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("drive word mismatch at %0t: expected m%0d dir %0d duty %0d",
                              $realtime, want.motor, want.dir, want.duty,
                              " level %0d delta %0d, got m%0d dir %0d duty %0d",
                              want.level, want.delta, rsp_ch.motor_out, rsp_ch.direction,
                              rsp_ch.duty, " level %0d delta %0d",
                              rsp_ch.drive_level, rsp_ch.measured_delta);
               end
            end
         end
      end
      pending_words <= drive_q.size();
   end

endmodule

>>> test/tb.sv
// Testbench top: clock, reset, control tick and register stimulus, result sink and verdict.
`timescale 1ns / 100ps

module tb;
   import mipd_pkg::*;

   localparam int  CYCLE_LIMIT  = 400000;
   localparam int  PHASES       = 8;
   localparam int  PHASE_TICKS  = 150;
   localparam int  HOLD_CYCLES  = 300;
   localparam int  TAIL_CYCLES  = 20;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatches;
   int                    pending_words;
   int                    cycles;

   bit idle_on;
   bit long_hold_req;
   bit long_hold_done;

   mipd_req_if req_if ();
   mipd_rsp_if rsp_if ();

   motor_incremental_pid_drive dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mipd_drive_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_ch        (req_if),
      .rsp_ch        (rsp_if),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .mismatches    (mismatches),
      .pending_words (pending_words)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycles = 0;
      while (cycles <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb NOT OK");
      $finish;
   end

   // result sink: random stalls, plus one long hold-off so the pipe backs up
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         if (long_hold_req && !long_hold_done) begin
            rsp_if.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold_done = 1'b1;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_tick(input logic [MIDX_W-1:0] motor, input logic [DATA_W-1:0] count,
                            input logic [DATA_W-1:0] target);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.motor_index   <= motor;
      req_if.encoder_count <= count;
      req_if.set_speed     <= target;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // csr_we stays high across back-to-back writes; csr_release drops it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic csr_release();
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 5))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return '0;
         3:       return DATA_W'($urandom_range(0, 65535));
         default: return DATA_W'($urandom_range(0, 600)) - 16'd300;
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 4))
         0:       return '0;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return CSR_DATA_W'($urandom_range(0, 65535));
         default: return CSR_DATA_W'($urandom_range(0, 2000));
      endcase
   endfunction

   task automatic random_regs();
      write_reg(CSR_GAIN_P, pick_gain());
      write_reg(CSR_GAIN_I, pick_gain());
      write_reg(CSR_GAIN_D, pick_gain());
      write_reg(CSR_PWM_LIMIT, pick_limit());
      write_reg(CSR_REV_MASK, CSR_DATA_W'($urandom_range(0, 65535)));
      csr_release();
   endtask

   // mostly small errors around the encoder midpoint so the loops settle and wind up
   task automatic random_tick();
      logic [MIDX_W-1:0] motor;
      logic [DATA_W-1:0] count, target;
      int sel;
      motor = MIDX_W'($urandom_range(0, 3));
      sel   = $urandom_range(0, 15);
      if (sel == 0) begin
         count  = DATA_W'($urandom_range(0, 65535));
         target = '0;
      end else if (sel < 3) begin
         count  = DATA_W'($urandom_range(0, 65535));
         target = DATA_W'($urandom_range(0, 65535));
      end else begin
         count  = DATA_W'(ENCODER_MID_DEF) + DATA_W'($urandom_range(0, 600)) - 16'd300;
         target = DATA_W'($urandom_range(0, 400)) - 16'd200;
      end
      send_tick(motor, count, target);
   endtask

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_if.valid         <= 1'b0;
      req_if.motor_index   <= '0;
      req_if.encoder_count <= '0;
      req_if.set_speed     <= '0;
      idle_on        = 1'b1;
      long_hold_req  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default gains, motors 1 and 3 reversed
      send_tick(2'd0, 16'd32768, 16'd100);
      send_tick(2'd0, 16'd0, 16'h7FFF);
      send_tick(2'd1, 16'd0, 16'h8000);      // reversed full-scale delta wraps
      send_tick(2'd1, 16'hFFFF, 16'd1);
      send_tick(2'd2, 16'hFFFF, 16'h8000);
      send_tick(2'd3, 16'd32769, 16'd0);
      send_tick(2'd0, 16'd32768, 16'd0);     // stop after being driven
      repeat (3) send_tick(2'd2, 16'd32768, 16'd5000);    // error sum hits its clamp
      repeat (3) send_tick(2'd2, 16'd32768, -16'sd5000);
      drain();

      // unity P gain: drive lands exactly on the negative extreme
      write_reg(CSR_GAIN_P, 16'd100);
      write_reg(CSR_GAIN_I, 16'd0);
      write_reg(CSR_GAIN_D, 16'd0);
      write_reg(CSR_PWM_LIMIT, 16'h7FFF);
      write_reg(CSR_REV_MASK, 16'd0);
      for (int i = int'(CSR_REV_MASK) + 1; i < 2 ** CSR_IDX_W; i++)
         write_reg(CSR_IDX_W'(i), CSR_DATA_W'($urandom_range(0, 65535)));
      csr_release();
      send_tick(2'd0, 16'd32768, 16'h8000);
      send_tick(2'd0, 16'd32768, 16'h7FFF);
      send_tick(2'd1, 16'd0, 16'h7FFF);
      send_tick(2'd3, 16'd32768, 16'h8000);
      drain();

      // extreme gains, zero limit, every motor reversed
      write_reg(CSR_GAIN_P, 16'h8000);
      write_reg(CSR_GAIN_I, 16'h7FFF);
      write_reg(CSR_GAIN_D, 16'h8000);
      write_reg(CSR_PWM_LIMIT, 16'd0);
      write_reg(CSR_REV_MASK, 16'd15);
      csr_release();
      send_tick(2'd0, 16'd0, 16'h7FFF);
      send_tick(2'd1, 16'hFFFF, 16'h8000);
      send_tick(2'd2, 16'd32767, 16'd1);
      send_tick(2'd3, 16'd32768, 16'hFFFF);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         random_regs();
         idle_on = (p != 0) && (p < PHASES - 2);
         if (p == 0)
            long_hold_req = 1'b1;
         repeat (PHASE_TICKS) random_tick();
         drain();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_words == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

>>> files.f
hw/rtl/mipd_pkg.sv
hw/rtl/mipd_req_if.sv
hw/rtl/mipd_rsp_if.sv
hw/rtl/mipd_div100.sv
hw/rtl/motor_incremental_pid_drive.sv
test/mipd_drive_checker.sv
test/tb.sv
